// ----- rtl/cab_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cab_pkg
// Shared types, constants and helpers for the cell area datapath.
// ----------------------------------------------------------------------------
package cab_pkg;

	localparam int LenW   = 16;
	localparam int ValW   = 24;
	localparam int DenW   = ValW + 1;
	localparam int FracW  = 17;
	localparam int QuotW  = 16;
	localparam int AreaW  = 32;
	localparam int DivStages = QuotW;
	localparam logic [FracW-1:0] FracOne = 17'h10000;

	localparam logic [1:0] KIND_ONE   = 2'd0;
	localparam logic [1:0] KIND_THREE = 2'd1;
	localparam logic [1:0] KIND_TWO   = 2'd2;
	localparam logic [1:0] KIND_NONE  = 2'd3;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_TRI,
		OP_TRI_SUB,
		OP_TRAP,
		OP_DIAG
	} op_t;

	// Per-edge setup ahead of the divider.
	typedef struct packed {
		logic [ValW-1:0] num;
		logic [DenW-1:0] den;
		logic            fixed;     // fraction settled without division
		logic            fixed_one; // settled value is one (else zero)
	} edge_t;

	// Item data that rides beside the dividers.
	typedef struct packed {
		logic [LenW-1:0] width;
		logic [LenW-1:0] height;
		logic [1:0]      kind;
		logic [3:0]      pos;       // corner value above zero
		logic [3:0]      fixed;
		logic [3:0]      fixed_one;
	} pay_t;

	function automatic edge_t edge_setup(input logic signed [ValW-1:0] fa,
	                                     input logic signed [ValW-1:0] fb);
		edge_t                  e;
		logic signed [DenW-1:0] d;
		logic                   fa_pos;
		logic                   d_pos;
		logic [DenW-1:0]        an;
		logic [DenW-1:0]        ad;
		d      = DenW'(fa) - DenW'(fb);
		fa_pos = !fa[ValW-1] && (fa != '0);
		d_pos  = !d[DenW-1] && (d != '0);
		an     = fa[ValW-1] ? DenW'(-DenW'(fa)) : DenW'(fa);
		ad     = d[DenW-1] ? DenW'(-d) : DenW'(d);
		e.num       = an[ValW-1:0];
		e.den       = ad;
		e.fixed     = 1'b1;
		e.fixed_one = 1'b0;
		if (d == '0) begin
			e.fixed_one = fa_pos;
		end else if (fa == '0 || fa_pos != d_pos) begin
			e.fixed_one = 1'b0;
		end else if (an >= ad) begin
			e.fixed_one = 1'b1;
		end else begin
			e.fixed = 1'b0;
		end
		return e;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/cab_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cab_div
// Pipelined restoring divider, one quotient bit per stage: num * 2^16 / den.
// ----------------------------------------------------------------------------
module cab_div
	import cab_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             en,
	input  wire logic [ValW-1:0]  num,
	input  wire logic [DenW-1:0]  den,
	output logic      [QuotW-1:0] quot
);

	logic [DenW-1:0]  rem_s  [0:DivStages];
	logic [DenW-1:0]  den_s  [0:DivStages];
	logic [QuotW-1:0] quot_s [0:DivStages];

	assign rem_s[0]  = DenW'(num);
	assign den_s[0]  = den;
	assign quot_s[0] = '0;

	for (genvar i = 0; i < DivStages; i++) begin : g_stage
		logic [DenW:0] shifted;
		logic          take;
		assign shifted = {rem_s[i], 1'b0};
		assign take    = shifted >= {1'b0, den_s[i]};

		// advance one quotient bit
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1]  <= take ? DenW'(shifted - {1'b0, den_s[i]}) : DenW'(shifted);
				den_s[i+1]  <= den_s[i];
				quot_s[i+1] <= {quot_s[i][QuotW-2:0], take};
			end
		end
	end

	assign quot = quot_s[DivStages];

endmodule
`default_nettype wire

// ----- rtl/cell_area_below_level_set_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cell_area_below_level_set_top
// Area of the positive part of one grid cell from its four corner values.
// ----------------------------------------------------------------------------
//  channel  handshake                   payload
//  item     item_valid / item_stall     cell_width, cell_height, value_corner0..3, cut_kind
//  result   result_valid / result_stall inside_area, diagonal_error
//
//  One transaction enters per cycle while no stalled result holds the pipeline;
//  its stages are edge setup, 16 divider stages, leg multiply, area multiply, final select.
//  There are four 16-stage pipelined dividers, one per edge.
//  A stalled result freezes the whole pipeline; item_stall follows it.
//  Reset clears only the valid bits.
// ----------------------------------------------------------------------------
module cell_area_below_level_set_top
	import cab_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   item_valid,
	output logic                        item_stall,
	input  wire logic [LenW-1:0]        cell_width,
	input  wire logic [LenW-1:0]        cell_height,
	input  wire logic signed [ValW-1:0] value_corner0,
	input  wire logic signed [ValW-1:0] value_corner1,
	input  wire logic signed [ValW-1:0] value_corner2,
	input  wire logic signed [ValW-1:0] value_corner3,
	input  wire logic [1:0]             cut_kind,
	output logic                        result_valid,
	input  wire logic                   result_stall,
	output logic [AreaW-1:0]            inside_area,
	output logic                        diagonal_error
);

	// Whole pipeline moves together; hold everything while a result is stalled.
	logic adv;
	assign adv        = !result_valid || !result_stall;
	assign item_stall = !adv;

	// ---- stage 1: edge setup ------------------------------------------------
	// edges: 0 = corner0->1, 1 = 0->2, 2 = 1->3, 3 = 2->3
	edge_t edge_c [0:3];
	edge_t edge_s1 [0:3];
	pay_t  pay_c;

	assign edge_c[0] = edge_setup(value_corner0, value_corner1);
	assign edge_c[1] = edge_setup(value_corner0, value_corner2);
	assign edge_c[2] = edge_setup(value_corner1, value_corner3);
	assign edge_c[3] = edge_setup(value_corner2, value_corner3);

	always_comb begin
		pay_c.width  = cell_width;
		pay_c.height = cell_height;
		pay_c.kind   = cut_kind;
		pay_c.pos    = {!value_corner3[ValW-1] && (value_corner3 != '0),
		                !value_corner2[ValW-1] && (value_corner2 != '0),
		                !value_corner1[ValW-1] && (value_corner1 != '0),
		                !value_corner0[ValW-1] && (value_corner0 != '0)};
		for (int e = 0; e < 4; e++) begin
			pay_c.fixed[e]     = edge_c[e].fixed;
			pay_c.fixed_one[e] = edge_c[e].fixed_one;
		end
	end

	// payload and valid delay line beside the dividers
	pay_t pay_d [0:DivStages];
	logic vld_d [0:DivStages];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= DivStages; i++) vld_d[i] <= 1'b0;
		end else if (adv) begin
			vld_d[0] <= item_valid;
			for (int i = 1; i <= DivStages; i++) vld_d[i] <= vld_d[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pay_d[0] <= pay_c;
			for (int i = 0; i < 4; i++) edge_s1[i] <= edge_c[i];
			for (int i = 1; i <= DivStages; i++) pay_d[i] <= pay_d[i-1];
		end
	end

	// ---- divider stages -----------------------------------------------------
	logic [QuotW-1:0] quot [0:3];

	for (genvar e = 0; e < 4; e++) begin : g_div
		cab_div u_div (
			.clk  (clk),
			.en   (adv),
			.num  (edge_s1[e].num),
			.den  (edge_s1[e].den),
			.quot (quot[e])
		);
	end

	// ---- leg stage: pick cut shape and scale fractions by edge length -------
	pay_t             pd;
	logic [FracW-1:0] lam [0:3];
	logic [FracW-1:0] cmp [0:3];
	logic [FracW-1:0] fa_c, fb_c;
	logic [LenW-1:0]  lena_c, lenb_c, outer_c;
	op_t              op_c;
	logic [LenW+FracW-1:0] proda_c, prodb_c;

	assign pd = pay_d[DivStages];

	always_comb begin
		for (int e = 0; e < 4; e++) begin
			lam[e] = pd.fixed[e] ? (pd.fixed_one[e] ? FracOne : '0) : FracW'(quot[e]);
			cmp[e] = FracOne - lam[e];
		end
		fa_c    = '0;
		fb_c    = '0;
		lena_c  = pd.width;
		lenb_c  = pd.height;
		outer_c = pd.width;
		op_c    = OP_NONE;
		case (pd.kind)
			KIND_ONE, KIND_THREE: begin
				logic [3:0] m;
				m = (pd.kind == KIND_ONE) ? pd.pos : ~pd.pos;
				if (m[0]) begin
					fa_c = lam[0]; fb_c = lam[1];
				end else if (m[1]) begin
					fa_c = cmp[0]; fb_c = lam[2];
				end else if (m[2]) begin
					fa_c = lam[3]; fb_c = cmp[1];
				end else begin
					fa_c = cmp[3]; fb_c = cmp[2];
				end
				if (m != '0) op_c = (pd.kind == KIND_ONE) ? OP_TRI : OP_TRI_SUB;
			end
			KIND_TWO: begin
				op_c = OP_TRAP;
				if (pd.pos[0] && pd.pos[1]) begin
					lena_c = pd.height; lenb_c = pd.height; outer_c = pd.width;
					fa_c = lam[1]; fb_c = lam[2];
				end else if (pd.pos[0] && pd.pos[2]) begin
					lena_c = pd.width; lenb_c = pd.width; outer_c = pd.height;
					fa_c = lam[0]; fb_c = lam[3];
				end else if (pd.pos[1] && pd.pos[3]) begin
					lena_c = pd.width; lenb_c = pd.width; outer_c = pd.height;
					fa_c = cmp[0]; fb_c = cmp[3];
				end else if (pd.pos[2] && pd.pos[3]) begin
					lena_c = pd.height; lenb_c = pd.height; outer_c = pd.width;
					fa_c = cmp[1]; fb_c = cmp[2];
				end else if ((pd.pos[0] && pd.pos[3]) || (pd.pos[1] && pd.pos[2])) begin
					op_c = OP_DIAG;
				end else begin
					op_c = OP_NONE;
				end
			end
			default: op_c = OP_NONE;
		endcase
		proda_c = (LenW+FracW)'(lena_c) * (LenW+FracW)'(fa_c);
		prodb_c = (LenW+FracW)'(lenb_c) * (LenW+FracW)'(fb_c);
	end

	logic [LenW-1:0] lega_s2, legb_s2, outer_s2, width_s2, height_s2;
	op_t             op_s2;
	logic            vld_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_d[DivStages];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// a leg never exceeds its length, so the top bit drops
			lega_s2   <= proda_c[LenW+QuotW-1:QuotW];
			legb_s2   <= prodb_c[LenW+QuotW-1:QuotW];
			outer_s2  <= outer_c;
			width_s2  <= pd.width;
			height_s2 <= pd.height;
			op_s2     <= op_c;
		end
	end

	// ---- area stage: triangle or trapezoid product, full cell area ----------
	logic [AreaW:0]   prod_c;
	logic [AreaW:0]   prod_s3;
	logic [AreaW-1:0] wh_s3;
	op_t              op_s3;
	logic             vld_s3;

	always_comb begin
		if (op_s2 == OP_TRAP) begin
			prod_c = (AreaW+1)'(outer_s2) * ((AreaW+1)'(lega_s2) + (AreaW+1)'(legb_s2));
		end else begin
			prod_c = (AreaW+1)'(lega_s2) * (AreaW+1)'(legb_s2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s3 <= prod_c;
			wh_s3   <= AreaW'(width_s2) * AreaW'(height_s2);
			op_s3   <= op_s2;
		end
	end

	// ---- output register ----------------------------------------------------
	logic [AreaW-1:0] half;
	assign half = prod_s3[AreaW:1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (adv) begin
			result_valid <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			case (op_s3)
				OP_TRI:     inside_area <= half;
				OP_TRI_SUB: inside_area <= wh_s3 - half;
				OP_TRAP:    inside_area <= half;
				default:    inside_area <= '0;
			endcase
			diagonal_error <= (op_s3 == OP_DIAG);
		end
	end

endmodule
`default_nettype wire
